// ===== design/prf_pkg.sv =====
// Shared types and codes for the packet ring FIFO.
// No dependencies; imported by packet_ring_fifo_top.
`default_nettype none

package prf_pkg;

    localparam int REQ_W   = 2;
    localparam int WIDX_W  = 8;
    localparam int DATA_W  = 64;
    localparam int SEC_W   = 32;
    localparam int USEC_W  = 20;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = 64;
    localparam int FILL_W  = 7;
    localparam int META_W  = SEC_W + USEC_W + 2 * LEN_W;

    typedef logic [REQ_W-1:0] t_req;
    typedef logic [1:0]       t_status;

    localparam t_req REQ_PUSH_WORD   = 2'd0;
    localparam t_req REQ_PUSH_COMMIT = 2'd1;
    localparam t_req REQ_READ_WORD   = 2'd2;
    localparam t_req REQ_POP         = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

endpackage

`default_nettype wire

// ===== design/prf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for slot data words and slot metadata.
`default_nettype none

module prf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/packet_ring_fifo_top.sv =====
// Packet capture ring FIFO top level: pointers, counters, result register.
// Depends on prf_pkg and prf_ram (slot word memory and slot metadata memory).
`default_nettype none

// Packet capture ring of RING_SLOTS slots, each FRAME_WORDS 64-bit words plus a
// timestamp and two lengths. Requests: push word, push commit (drops and counts
// when full), read word and pop from the tail (empty reports status, never
// blocks). Every request gives exactly one result. One request is in flight at a
// time: it is accepted, the slot memories are read at the accepting edge through
// their registered read port, and the result register then loads the returned
// data. The next request is accepted in the cycle its predecessor's result is
// taken, so a new request cannot be taken until the previous result has been
// registered and, when the result side stalls, consumed. Memory contents need no
// clearing after reset; unwritten words read as undefined.
module packet_ring_fifo_top
    import prf_pkg::*;
#(
    parameter int RING_SLOTS  = 64,
    parameter int FRAME_WORDS = 190
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [WIDX_W-1:0] i_word_index,
    input  wire logic [DATA_W-1:0] i_data_word,
    input  wire logic [SEC_W-1:0]  i_ts_sec,
    input  wire logic [USEC_W-1:0] i_ts_usec,
    input  wire logic [LEN_W-1:0]  i_cap_length,
    input  wire logic [LEN_W-1:0]  i_orig_length,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_status,
    output logic [DATA_W-1:0]      o_read_word,
    output logic [SEC_W-1:0]       o_out_ts_sec,
    output logic [USEC_W-1:0]      o_out_ts_usec,
    output logic [LEN_W-1:0]       o_out_cap_length,
    output logic [LEN_W-1:0]       o_out_orig_length,
    output logic [CNT_W-1:0]       o_captured_count,
    output logic [CNT_W-1:0]       o_dropped_count,
    output logic [CNT_W-1:0]       o_processed_count,
    output logic [FILL_W-1:0]      o_fill_level
);

    localparam int PW      = $clog2(2 * RING_SLOTS);
    localparam int SW      = $clog2(RING_SLOTS);
    localparam int WDEPTH  = RING_SLOTS * FRAME_WORDS;
    localparam int WAW     = $clog2(WDEPTH);
    localparam int EW      = (PW > FILL_W) ? PW : FILL_W;
    localparam logic [PW-1:0] SLOTS_P   = PW'(RING_SLOTS);
    localparam logic [PW-1:0] PTR_LAST  = PW'(2 * RING_SLOTS - 1);
    localparam logic [PW:0]   PTR_MOD   = (PW+1)'(2 * RING_SLOTS);
    localparam logic [WIDX_W:0] FRAME_LIM = (WIDX_W+1)'(FRAME_WORDS);

    logic [PW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [CNT_W-1:0] r_cap_cnt, r_drop_cnt, r_proc_cnt;
    logic [CNT_W-1:0] n_cap_cnt, n_drop_cnt, n_proc_cnt;
    logic             r_busy;
    t_status          r_pend_status, n_status;
    logic             r_pend_word, r_pend_pop, n_word_ok, n_pop_ok;
    logic             r_out_valid;

    t_status          r_status;
    logic [DATA_W-1:0] r_read_word;
    logic [SEC_W-1:0]  r_ts_sec;
    logic [USEC_W-1:0] r_ts_usec;
    logic [LEN_W-1:0]  r_cap_len, r_orig_len;
    logic [CNT_W-1:0]  r_cap_out, r_drop_out, r_proc_out;
    logic [FILL_W-1:0] r_fill;

    logic             in_fire;
    logic             range_bad, full, empty;
    logic [PW:0]      occ_sum;
    logic [PW-1:0]    occ;
    logic [EW-1:0]    occ_ext;
    logic [PW-1:0]    wslot_p, rslot_p;
    logic [SW-1:0]    wslot, rslot;
    logic [WAW-1:0]   word_waddr, word_raddr;
    logic             word_we, meta_we;
    logic [DATA_W-1:0] word_rdata;
    logic [META_W-1:0] meta_wdata, meta_rdata;

    assign o_in_ready = !r_busy && (!r_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;

    // Occupancy modulo twice the slot count
    assign occ_sum = (r_wp >= r_rp) ? ((PW+1)'(r_wp) - (PW+1)'(r_rp))
                                    : ((PW+1)'(r_wp) + PTR_MOD - (PW+1)'(r_rp));
    assign occ     = occ_sum[PW-1:0];
    assign occ_ext = EW'(occ);
    assign full    = (occ == SLOTS_P);
    assign empty   = (r_wp == r_rp);

    assign wslot_p = (r_wp >= SLOTS_P) ? (r_wp - SLOTS_P) : r_wp;
    assign rslot_p = (r_rp >= SLOTS_P) ? (r_rp - SLOTS_P) : r_rp;
    assign wslot   = wslot_p[SW-1:0];
    assign rslot   = rslot_p[SW-1:0];

    assign range_bad  = ({1'b0, i_word_index} >= FRAME_LIM);
    assign word_waddr = WAW'(WAW'(wslot) * WAW'(FRAME_WORDS) + WAW'(i_word_index));
    assign word_raddr = WAW'(WAW'(rslot) * WAW'(FRAME_WORDS) + WAW'(i_word_index));
    assign meta_wdata = {i_ts_sec, i_ts_usec, i_cap_length, i_orig_length};

    always_comb begin
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_cap_cnt  = r_cap_cnt;
        n_drop_cnt = r_drop_cnt;
        n_proc_cnt = r_proc_cnt;
        n_status   = ST_OK;
        n_word_ok  = 1'b0;
        n_pop_ok   = 1'b0;
        word_we    = 1'b0;
        meta_we    = 1'b0;
        unique case (i_req_type)
            REQ_PUSH_WORD: begin
                if (range_bad) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    word_we = in_fire;
                end
            end
            REQ_PUSH_COMMIT: begin
                n_cap_cnt = r_cap_cnt + 1'b1;
                if (full) begin
                    n_drop_cnt = r_drop_cnt + 1'b1;
                    n_status   = ST_FULL;
                end else begin
                    meta_we = in_fire;
                    n_wp    = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
                end
            end
            REQ_READ_WORD: begin
                if (range_bad) begin
                    n_status = ST_RANGE;
                end else if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_word_ok = 1'b1;
                end
            end
            REQ_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_pop_ok   = 1'b1;
                    n_rp       = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
                    n_proc_cnt = r_proc_cnt + 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    prf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WDEPTH)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (word_we),
        .i_waddr (word_waddr),
        .i_wdata (i_data_word),
        .i_raddr (word_raddr),
        .o_rdata (word_rdata)
    );

    prf_ram #(
        .WIDTH (META_W),
        .DEPTH (RING_SLOTS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (wslot),
        .i_wdata (meta_wdata),
        .i_raddr (rslot),
        .o_rdata (meta_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_cap_cnt   <= '0;
            r_drop_cnt  <= '0;
            r_proc_cnt  <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= in_fire;
            if (in_fire) begin
                r_wp       <= n_wp;
                r_rp       <= n_rp;
                r_cap_cnt  <= n_cap_cnt;
                r_drop_cnt <= n_drop_cnt;
                r_proc_cnt <= n_proc_cnt;
            end
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: request decision, then result once memory data is back
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pend_status <= n_status;
            r_pend_word   <= n_word_ok;
            r_pend_pop    <= n_pop_ok;
        end
        if (r_busy) begin
            r_status    <= r_pend_status;
            r_read_word <= r_pend_word ? word_rdata : '0;
            r_ts_sec    <= r_pend_pop ? meta_rdata[META_W-1 -: SEC_W] : '0;
            r_ts_usec   <= r_pend_pop ? meta_rdata[2*LEN_W +: USEC_W] : '0;
            r_cap_len   <= r_pend_pop ? meta_rdata[LEN_W +: LEN_W] : '0;
            r_orig_len  <= r_pend_pop ? meta_rdata[LEN_W-1:0] : '0;
            r_cap_out   <= r_cap_cnt;
            r_drop_out  <= r_drop_cnt;
            r_proc_out  <= r_proc_cnt;
            r_fill      <= occ_ext[FILL_W-1:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_read_word       = r_read_word;
    assign o_out_ts_sec      = r_ts_sec;
    assign o_out_ts_usec     = r_ts_usec;
    assign o_out_cap_length  = r_cap_len;
    assign o_out_orig_length = r_orig_len;
    assign o_captured_count  = r_cap_out;
    assign o_dropped_count   = r_drop_out;
    assign o_processed_count = r_proc_out;
    assign o_fill_level      = r_fill;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ <= SLOTS_P)
        else $error("ring occupancy above slot count");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp <= PTR_LAST) && (r_rp <= PTR_LAST))
        else $error("pointer outside modulo range");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> ##1 o_out_valid)
        else $error("no result two cycles after transfer");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("second request in flight");

    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |-> (o_fill_level == '0))
        else $error("empty status with nonzero fill");
`endif

endmodule

`default_nettype wire
